// File: rtl/lmfs_pkg.sv
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types and constants for the LED matrix frame store shift-out unit.
// ----------------------------------------------------------------------------
package lmfs_pkg;

  // Frame store geometry (fixed by the field widths)
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned XW         = 8;
  localparam int unsigned YW         = 6;

  // Pixel command codes
  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } lmfs_cmd_e;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WR_RD  = 5'b00010,
    S_WR_MOD = 5'b00100,
    S_FL_RD  = 5'b01000,
    S_FL_OUT = 5'b10000
  } lmfs_state_e;

  // Request from the sequencer to the frame store
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] wdata;
  } lmfs_mem_req_t;

endpackage

// File: rtl/lmfs_if.sv
// ----------------------------------------------------------------------------
// lmfs_in_if / lmfs_out_if
// Valid/ready channels for pixel commands and flushed frame bytes.
// ----------------------------------------------------------------------------
interface lmfs_in_if import lmfs_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          command;
  logic [XW-1:0] pixel_x;
  logic [YW-1:0] pixel_y;
  logic          pixel_on;

  modport source (output valid, command, pixel_x, pixel_y, pixel_on, input ready);
  modport sink   (input valid, command, pixel_x, pixel_y, pixel_on, output ready);
endinterface

interface lmfs_out_if import lmfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic [AddrW-1:0] byte_index;
  logic             last_byte;

  modport source (output valid, out_byte, byte_index, last_byte, input ready);
  modport sink   (input valid, out_byte, byte_index, last_byte, output ready);
endinterface

// File: rtl/lmfs_store.sv
// ----------------------------------------------------------------------------
// lmfs_store
// 64 x 8 frame memory, one access per cycle, registered read. Per-entry
// valid flops make unwritten entries read as zero straight after reset.
// ----------------------------------------------------------------------------
module lmfs_store import lmfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lmfs_mem_req_t    req_i,
  output logic [ByteW-1:0] rd_data_o
);

  logic [ByteW-1:0]      mem_q [StoreDepth];
  logic [StoreDepth-1:0] written_q;
  logic [ByteW-1:0]      rdata_q;
  logic                  rvalid_q;

  // Memory array and read data register
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  // Written flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvalid_q <= written_q[req_i.addr];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

// File: rtl/led_matrix_frame_store_shift_out_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_frame_store_shift_out_unit
// One-bit LED matrix frame store with a byte stream for a shift-register panel.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                           | transfer when
//  ---------+-----+-----------------------------------+--------------------
//  in_i     | in  | command, pixel_x, pixel_y, pixel_on | valid & ready
//  out_o    | out | out_byte, byte_index, last_byte   | valid & ready
//
//  A pixel write holds the input through accept, memory read and write back;
//  a dropped pixel is accepted and ignored. A flush reads and sends each of its
//  (HEIGHT/8)*WIDTH bytes, at most 64, in turn through the single registered
//  port of the frame memory. Output stalls hold the current byte and pause
//  the flush. Reset clears the frame at once through per-entry written flags.
// ----------------------------------------------------------------------------
module led_matrix_frame_store_shift_out_unit import lmfs_pkg::*; #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned HEIGHT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lmfs_in_if.sink   in_i,
  lmfs_out_if.source out_o
);

  localparam int unsigned RawBytes   = (HEIGHT / 8) * WIDTH;
  localparam int unsigned FrameBytes = (RawBytes > StoreDepth) ? StoreDepth : RawBytes;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(FrameBytes - 1);
  localparam int unsigned IdxW = 11;

  lmfs_state_e      state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [ByteW-1:0] mask_q, mask_d;
  logic             on_q, on_d;

  logic [XW:0]      x_rev;
  logic [YW:0]      y_rev;
  logic [IdxW-1:0]  idx_wide;
  logic             pix_ok;
  logic             in_xfer, out_xfer;
  lmfs_mem_req_t    mem_req;
  logic [ByteW-1:0] rd_data;

  // Mirror coordinates and form the byte index
  always_comb begin
    x_rev    = (XW+1)'(WIDTH - 1) - {1'b0, in_i.pixel_x};
    y_rev    = (YW+1)'(HEIGHT - 1) - {1'b0, in_i.pixel_y};
    idx_wide = IdxW'(y_rev[YW-1:3]) * IdxW'(WIDTH) + IdxW'(x_rev[XW-1:0]);
    pix_ok   = ({1'b0, in_i.pixel_x} < (XW+1)'(WIDTH)) &&
               ({1'b0, in_i.pixel_y} < (YW+1)'(HEIGHT)) &&
               (idx_wide < IdxW'(FrameBytes));
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;

  // Sequencer
  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    mask_d        = mask_q;
    on_d          = on_q;
    mem_req.wr_en = 1'b0;
    mem_req.rd_en = 1'b0;
    mem_req.addr  = addr_q;
    mem_req.wdata = on_q ? (rd_data | mask_q) : (rd_data & ~mask_q);
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_i.command == CMD_FLUSH) begin
            addr_d  = '0;
            state_d = S_FL_RD;
          end else if (pix_ok) begin
            addr_d  = idx_wide[AddrW-1:0];
            mask_d  = 8'h80 >> y_rev[2:0];
            on_d    = in_i.pixel_on;
            state_d = S_WR_RD;
          end
        end
      end
      S_WR_RD: begin
        mem_req.rd_en = 1'b1;
        state_d       = S_WR_MOD;
      end
      S_WR_MOD: begin
        mem_req.wr_en = 1'b1;
        state_d       = S_IDLE;
      end
      S_FL_RD: begin
        mem_req.rd_en = 1'b1;
        state_d       = S_FL_OUT;
      end
      S_FL_OUT: begin
        if (out_xfer) begin
          if (addr_q == LastIdx) begin
            state_d = S_IDLE;
          end else begin
            addr_d  = addr_q + 1'b1;
            state_d = S_FL_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    mask_q <= mask_d;
    on_q   <= on_d;
  end

  lmfs_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_data_o(rd_data)
  );

  // Output: read data stays put until the next read, so it holds under stall
  assign out_o.valid      = (state_q == S_FL_OUT);
  assign out_o.out_byte   = rd_data;
  assign out_o.byte_index = addr_q;
  assign out_o.last_byte  = (addr_q == LastIdx);

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the LED matrix frame store shift-out unit with random pixel writes
// and flushes. A local copy of the mirrored frame predicts every flushed byte,
// and the bytes that come out are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb import lmfs_pkg::*; ();

  localparam int unsigned WIDTH      = 32;
  localparam int unsigned HEIGHT     = 16;
  localparam int unsigned RAND_ITEMS = 330;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam int unsigned CALM_TAIL  = 40;

  typedef struct packed {
    lmfs_cmd_e     command;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          on;
  } pixel_cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [AddrW-1:0] index;
    logic             last;
  } frame_byte_t;

  logic clk_i;
  logic rst_ni;

  lmfs_in_if  in_if ();
  lmfs_out_if out_if ();

  led_matrix_frame_store_shift_out_unit #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  pixel_cmd_t       pend_q[$];
  frame_byte_t      flush_bytes_q[$];
  logic [ByteW-1:0] frame_mirror[StoreDepth];
  int unsigned      items_total;
  int unsigned      accepted_cnt;
  int unsigned      err_cnt;
  int unsigned      cycle_cnt;
  bit               in_taken;
  int unsigned      src_gap;
  int unsigned      snk_gap;

  // Clock, reset and known input levels from time zero
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.command = CMD_PIXEL;
    in_if.pixel_x = '0;
    in_if.pixel_y = '0;
    in_if.pixel_on = 1'b0;
    out_if.ready  = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic pixel_cmd_t mk_cmd(lmfs_cmd_e c, int unsigned x, int unsigned y, bit on);
    pixel_cmd_t p;
    p.command = c;
    p.x       = x[XW-1:0];
    p.y       = y[YW-1:0];
    p.on      = on;
    return p;
  endfunction

  // Mirror the pixel into the local frame, or queue the bytes a flush sends
  task automatic track_frame(input pixel_cmd_t c);
    int unsigned xr;
    int unsigned yr;
    int unsigned idx;
    int unsigned nbytes;
    frame_byte_t fb;
    nbytes = (HEIGHT / 8) * WIDTH;
    if (nbytes > StoreDepth) nbytes = StoreDepth;
    if (c.command == CMD_PIXEL) begin
      if (c.x < WIDTH && c.y < HEIGHT) begin
        xr  = WIDTH - 1 - c.x;
        yr  = HEIGHT - 1 - c.y;
        idx = (yr / 8) * WIDTH + xr;
        if (idx < nbytes) begin
          if (c.on) frame_mirror[idx] = frame_mirror[idx] | (8'h80 >> (yr % 8));
          else      frame_mirror[idx] = frame_mirror[idx] & ~(8'h80 >> (yr % 8));
        end
      end
    end else begin
      for (int unsigned k = 0; k < nbytes; k++) begin
        fb.data  = frame_mirror[k];
        fb.index = k[AddrW-1:0];
        fb.last  = (k + 1 == nbytes);
        flush_bytes_q.push_back(fb);
      end
    end
  endtask

  // Input driver: holds each item until its transfer, random gap bursts
  always @(negedge clk_i) begin : drive_in
    pixel_cmd_t cur;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      in_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        in_if.valid <= 1'b0;
      end else if (pend_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (pend_q.size() > CALM_TAIL && cycle_cnt[8:7] != 2'd0 &&
                   $urandom_range(0, 4) == 0) begin
        src_gap = $urandom_range(0, 3);
        in_if.valid <= 1'b0;
      end else begin
        cur = pend_q.pop_front();
        in_if.valid    <= 1'b1;
        in_if.command  <= cur.command;
        in_if.pixel_x  <= cur.x;
        in_if.pixel_y  <= cur.y;
        in_if.pixel_on <= cur.on;
      end
    end
  end

  // Output ready with random stall bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_if.ready <= 1'b0;
    end else if (pend_q.size() > CALM_TAIL && cycle_cnt[9:8] != 2'd1 &&
                 $urandom_range(0, 3) == 0) begin
      snk_gap = $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk_i) begin : monitor
    pixel_cmd_t  got_cmd;
    frame_byte_t exp_b;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("[led_matrix_frame_store_shift_out_unit] ERROR");
      $finish;
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      got_cmd.command = lmfs_cmd_e'(in_if.command);
      got_cmd.x       = in_if.pixel_x;
      got_cmd.y       = in_if.pixel_y;
      got_cmd.on      = in_if.pixel_on;
      track_frame(got_cmd);
      accepted_cnt++;
      in_taken = 1'b1;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (flush_bytes_q.size() == 0) begin
        $error("unexpected byte: index %0d data %02h", out_if.byte_index, out_if.out_byte);
        err_cnt++;
      end else begin
        exp_b = flush_bytes_q.pop_front();
        if (out_if.out_byte !== exp_b.data) begin
          $error("out_byte: expected %02h, got %02h", exp_b.data, out_if.out_byte);
          err_cnt++;
        end
        if (out_if.byte_index !== exp_b.index) begin
          $error("byte_index: expected %0d, got %0d", exp_b.index, out_if.byte_index);
          err_cnt++;
        end
        if (out_if.last_byte !== exp_b.last) begin
          $error("last_byte: expected %0b, got %0b", exp_b.last, out_if.last_byte);
          err_cnt++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int unsigned r;
    int unsigned xs;
    int unsigned ys;
    bit          on;
    for (int i = 0; i < StoreDepth; i++) frame_mirror[i] = '0;
    accepted_cnt = 0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    in_taken     = 1'b0;
    src_gap      = 0;
    snk_gap      = 0;

    // Directed: empty frame, corners, drops at and beyond the edges,
    // a full byte then one bit cleared, a darkened corner
    pend_q.push_back(mk_cmd(CMD_FLUSH, 255, 63, 1));
    pend_q.push_back(mk_cmd(CMD_PIXEL, 0, 0, 1));
    pend_q.push_back(mk_cmd(CMD_PIXEL, WIDTH - 1, HEIGHT - 1, 1));
    pend_q.push_back(mk_cmd(CMD_PIXEL, WIDTH - 1, 0, 1));
    pend_q.push_back(mk_cmd(CMD_PIXEL, 0, HEIGHT - 1, 1));
    pend_q.push_back(mk_cmd(CMD_PIXEL, WIDTH, 3, 1));
    pend_q.push_back(mk_cmd(CMD_PIXEL, 255, 63, 1));
    pend_q.push_back(mk_cmd(CMD_PIXEL, 5, HEIGHT, 1));
    pend_q.push_back(mk_cmd(CMD_PIXEL, 7, 63, 1));
    for (int unsigned y = 0; y < 8; y++) pend_q.push_back(mk_cmd(CMD_PIXEL, 3, y, 1));
    pend_q.push_back(mk_cmd(CMD_FLUSH, 0, 0, 0));
    pend_q.push_back(mk_cmd(CMD_PIXEL, 3, 0, 0));
    pend_q.push_back(mk_cmd(CMD_PIXEL, 0, 0, 0));
    pend_q.push_back(mk_cmd(CMD_FLUSH, 170, 42, 0));

    // Random: mostly in-range pixels and column strokes, some noise, flushes
    r = 0;
    while (r < RAND_ITEMS) begin
      ys = $urandom_range(0, 99);
      if (ys < 6) begin
        pend_q.push_back(mk_cmd(CMD_FLUSH, $urandom_range(0, 255), $urandom_range(0, 63),
                                $urandom_range(0, 1)));
        r++;
      end else if (ys < 18) begin
        pend_q.push_back(mk_cmd(CMD_PIXEL, $urandom_range(0, 255), $urandom_range(0, 63),
                                $urandom_range(0, 1)));
        r++;
      end else if (ys < 28) begin
        xs = $urandom_range(0, WIDTH - 1);
        on = $urandom_range(0, 3) != 0;
        ys = 8 * $urandom_range(0, HEIGHT / 8 - 1);
        for (int unsigned y = 0; y < 8; y++) pend_q.push_back(mk_cmd(CMD_PIXEL, xs, ys + y, on));
        r += 8;
      end else begin
        pend_q.push_back(mk_cmd(CMD_PIXEL, $urandom_range(0, WIDTH - 1),
                                $urandom_range(0, HEIGHT - 1), $urandom_range(0, 4) != 0));
        r++;
      end
    end
    pend_q.push_back(mk_cmd(CMD_FLUSH, 0, 0, 0));
    items_total = pend_q.size();

    while (accepted_cnt < items_total || flush_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[led_matrix_frame_store_shift_out_unit] OK");
    end else begin
      $display("[led_matrix_frame_store_shift_out_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: led_matrix_frame_store_shift_out_unit.f
rtl/lmfs_pkg.sv
rtl/lmfs_if.sv
rtl/lmfs_store.sv
rtl/led_matrix_frame_store_shift_out_unit.sv
sim/tb.sv
